// File: hw/rtl/hft_pkg.sv
// Shared types and constants for the hashed forwarding table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hft_pkg;

  localparam int HFT_BUCKET_BITS = 10;
  localparam int HFT_WAYS        = 4;
  localparam int HFT_MAX_FANOUT  = 16;

  localparam logic [3:0] HFT_INDEX_BITS_RST = 4'd10;

  // Configuration register indexes (word address)
  localparam logic REG_INDEX_BITS = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_FLUSH  = 2'd3
  } hft_op_t;

  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_DUP  = 2'd1,
    RS_MISS = 2'd2,
    RS_FULL = 2'd3
  } hft_status_t;

  typedef struct packed {
    hft_op_t     opcode;
    logic [63:0] dest_addr;
    logic [15:0] port_group;
    logic [4:0]  fanout;
  } hft_req_t;

  typedef struct packed {
    hft_status_t status;
    logic [15:0] found_group;
    logic [4:0]  found_fanout;
  } hft_rsp_t;

  // One way of a bucket row
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] grp;
    logic [4:0]  fan;
  } hft_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FLUSH
  } hft_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic exec;
    logic clr_en;
  } hft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic req_flush;
    logic out_busy;
  } hft_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/hft_ctrl.sv
// Sequencing state machine of the forwarding table.
// Depends on hft_pkg; drives hft_datapath through hft_cmd_t.
`default_nettype none

module hft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  hft_pkg::hft_sts_t sts,
  output hft_pkg::hft_cmd_t cmd
);
  import hft_pkg::*;

  hft_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.req_flush) begin
          state_next = S_FLUSH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_FLUSH: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/hft_datapath.sv
// Bucket memory, way compare, row update and result register.
// Depends on hft_pkg; controlled by hft_ctrl.
`default_nettype none

module hft_datapath #(
  parameter int BUCKET_BITS = hft_pkg::HFT_BUCKET_BITS,
  parameter int WAYS        = hft_pkg::HFT_WAYS,
  parameter int MAX_FANOUT  = hft_pkg::HFT_MAX_FANOUT
) (
  input  logic              clk,
  input  logic              rst,
  input  hft_pkg::hft_cmd_t cmd,
  output hft_pkg::hft_sts_t sts,
  input  logic [3:0]        index_bits,
  input  hft_pkg::hft_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output hft_pkg::hft_rsp_t rsp
);
  import hft_pkg::*;

  localparam int NROWS = 1 << BUCKET_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = $bits(hft_entry_t);
  localparam int ROW_W = WAYS * (ENT_W + 1);
  localparam logic [6:0] MAXF = 7'(MAX_FANOUT);
  localparam logic [4:0] BB   = 5'(BUCKET_BITS);

  logic [ROW_W-1:0]       mem [NROWS];
  logic [ROW_W-1:0]       rd_row;
  hft_op_t                req_op;
  logic [63:0]            req_addr;
  logic [15:0]            req_grp;
  logic [4:0]             req_fan;
  logic [BUCKET_BITS-1:0] req_bucket;
  logic [BUCKET_BITS-1:0] clr_cnt;

  logic [4:0]             eff_bits;
  logic [BUCKET_BITS-1:0] bucket_mask;
  logic [WAYS-1:0]        row_valid, new_valid, hit_vec, free_vec;
  hft_entry_t [WAYS-1:0]  row_ent, new_ent;
  logic [WAY_W-1:0]       hit_way, free_way;
  logic                   hit, any_free, wr_row;
  logic [4:0]             fan_c;
  hft_rsp_t               rsp_next;
  logic                   mem_we;
  logic [BUCKET_BITS-1:0] mem_waddr;
  logic [ROW_W-1:0]       mem_wdata;

  // Bucket mask from the configured index width, capped at BUCKET_BITS
  always_comb begin
    eff_bits = ({1'b0, index_bits} > BB) ? BB : {1'b0, index_bits};
    for (int i = 0; i < BUCKET_BITS; i++) begin
      bucket_mask[i] = (i < int'(eff_bits));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op     <= req.opcode;
      req_addr   <= req.dest_addr;
      req_grp    <= req.port_group;
      req_fan    <= req.fanout;
      req_bucket <= req.dest_addr[BUCKET_BITS-1:0] & bucket_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    row_valid = rd_row[ROW_W-1 -: WAYS];
    row_ent   = rd_row[WAYS*ENT_W-1:0];
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_valid[w] && (row_ent[w].key == req_addr);
      free_vec[w] = !row_valid[w];
    end
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit      = |hit_vec;
    any_free = |free_vec;
  end

  // Clamp the stored count to 1..MAX_FANOUT
  always_comb begin
    if (req_fan == 5'd0) begin
      fan_c = 5'd1;
    end else if ({2'b00, req_fan} > MAXF) begin
      fan_c = MAXF[4:0];
    end else begin
      fan_c = req_fan;
    end
  end

  always_comb begin
    new_valid = row_valid;
    new_ent   = row_ent;
    wr_row    = 1'b0;
    rsp_next  = '0;
    unique case (req_op)
      OP_INSERT: begin
        if (hit) begin
          rsp_next.status = RS_DUP;
        end else if (any_free) begin
          new_valid[free_way] = 1'b1;
          new_ent[free_way]   = '{key: req_addr, grp: req_grp, fan: fan_c};
          wr_row              = 1'b1;
          rsp_next.status     = RS_OK;
        end else begin
          rsp_next.status = RS_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          rsp_next.status       = RS_OK;
          rsp_next.found_group  = row_ent[hit_way].grp;
          rsp_next.found_fanout = row_ent[hit_way].fan;
        end else begin
          rsp_next.status = RS_MISS;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          new_valid[hit_way] = 1'b0;
          wr_row             = 1'b1;
          rsp_next.status    = RS_OK;
        end else begin
          rsp_next.status = RS_MISS;
        end
      end
      OP_FLUSH: begin
        rsp_next.status = RS_OK;
      end
      default: begin
        rsp_next.status = RS_OK;
      end
    endcase
  end

  assign mem_we    = cmd.clr_en | (cmd.exec & wr_row);
  assign mem_waddr = cmd.clr_en ? clr_cnt : req_bucket;
  assign mem_wdata = cmd.clr_en ? '0 : {new_valid, new_ent};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_row <= mem[req_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  assign sts.clr_last  = &clr_cnt;
  assign sts.req_flush = (req_op == OP_FLUSH);
  assign sts.out_busy  = rsp_valid & rsp_stall;

endmodule

`default_nettype wire

// File: hw/rtl/hashed_forwarding_table_core.sv
// Top level of the hashed forwarding table: configuration register,
// controller and datapath. Depends on hft_pkg, hft_ctrl and hft_datapath.
`default_nettype none

// Forwarding table keyed by a 64-bit destination address. The bucket is the
// address masked to the low index_bits bits (capped at BUCKET_BITS); each
// bucket is one memory row of WAYS entries plus their valid bits. Insert,
// lookup and delete run as accept, row read and execute: accept captures
// the request, the row read loads the registered row, and execute compares
// all ways, writes the row back and loads the output register. Execute
// waits while the previous result is still held by rsp_stall. The bucket
// memory has one write port and one registered read port, and each request
// does a read-modify-write of one row. req_stall stays high until the
// result is loaded, and a request may be taken while the previous result
// still waits on rsp_stall. A flush sweeps the memory one row a cycle and
// then returns its result. After reset the same sweep runs with req_stall
// high; configuration writes are taken throughout. index_bits lives at
// byte address 0 of the APB-style port; write it only while the table is
// idle.
module hashed_forwarding_table_core #(
  parameter int BUCKET_BITS = hft_pkg::HFT_BUCKET_BITS,
  parameter int WAYS        = hft_pkg::HFT_WAYS,
  parameter int MAX_FANOUT  = hft_pkg::HFT_MAX_FANOUT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_stall,
  input  hft_pkg::hft_req_t req,
  // result channel
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output hft_pkg::hft_rsp_t rsp,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hft_pkg::*;

  logic       [3:0] index_bits;
  hft_cmd_t         cmd;
  hft_sts_t         sts;
  logic             cfg_wr;

  // Register write completes in the access phase; there are no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= HFT_INDEX_BITS_RST;
    end else if (cfg_wr && (paddr[2] == REG_INDEX_BITS)) begin
      index_bits <= pwdata[3:0];
    end
  end

  // Addresses past the register read as zero and drop writes.
  assign prdata = (paddr[2] == REG_INDEX_BITS) ? {28'd0, index_bits} : 32'd0;

  // Sequencer: reset sweep, accept, row read, compare/writeback, flush sweep
  hft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Bucket memory, way match and the result register
  hft_datapath #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS),
    .MAX_FANOUT  (MAX_FANOUT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .index_bits (index_bits),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
